// ===== rtl/cfdd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfdd_pkg
// Shared types and constants of the CAN frame byte deframer.
// ----------------------------------------------------------------------------
package cfdd_pkg;

   // largest payload a frame may carry
   localparam int unsigned MAX_PAYLOAD = 8;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_START  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_START = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_POLY     = 2'd2;

   // reset values of the configuration registers
   localparam logic [7:0]  FIRST_START_RST  = 8'hAB;
   localparam logic [7:0]  SECOND_START_RST = 8'hBA;
   localparam logic [31:0] CRC_POLY_RST     = 32'h04C1_1DB7;

   // result status codes
   localparam logic [1:0] ST_GOOD     = 2'd0;
   localparam logic [1:0] ST_MISMATCH = 2'd1;
   localparam logic [1:0] ST_LENGTH   = 2'd2;

   // commands to the bit-serial CRC unit
   typedef struct packed {
      logic init;   // preset the CRC register to all ones
      logic start;  // begin a 32-bit pass over the loaded group
   } crc_cmd_type;

   // status back from the CRC unit
   typedef struct packed {
      logic        busy;
      logic [15:0] check;  // low half of the inverted CRC
   } crc_sts_type;

endpackage

// ===== rtl/cfdd_crc.sv =====
// ----------------------------------------------------------------------------
// cfdd_crc
// Bit-serial CRC-32 unit: shifts one 4-byte group through the CRC register,
// highest lane first, one bit per clock.
// ----------------------------------------------------------------------------
module cfdd_crc
   import cfdd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  crc_cmd_type cmd,
   input  logic [31:0] group_word,
   input  logic [31:0] poly,
   output crc_sts_type sts
);

   logic [31:0] crc_ff, crc_in;
   logic [31:0] shift_ff, shift_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        fb;

   // one bit of the polynomial division per cycle
   always_comb begin
      crc_in   = crc_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      fb       = crc_ff[31] ^ shift_ff[31];
      if (cmd.init) begin
         crc_in = '1;
      end else if (cmd.start) begin
         shift_in = group_word;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         crc_in   = {crc_ff[30:0], 1'b0} ^ (fb ? poly : 32'd0);
         shift_in = {shift_ff[30:0], 1'b0};
         cnt_in   = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      crc_ff   <= crc_in;
      shift_ff <= shift_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.check = ~crc_ff[15:0];

endmodule

// ===== rtl/can_frame_byte_deframer.sv =====
// ----------------------------------------------------------------------------
// can_frame_byte_deframer
// Hunts two start bytes, collects length, identifier, payload and check
// bytes, and reports each frame with its CRC verdict and error counters.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake           | payload
//  req_      | in        | req_valid/req_stall | rx_byte
//  rsp_      | out       | rsp_valid/rsp_stall | status, ident, length, payload,
//            |           |                     | checks, counters
//  csr_      | in        | csr_we              | csr_index, csr_wdata
//
//  Most bytes are taken without a stall. A byte that completes a group of
//  four CRC bytes stalls the input while the CRC unit shifts the group one
//  bit per clock. The last check byte of a frame stalls it while a padded
//  final group, if any, is shifted and while the result register is loaded.
//  Reset is synchronous and clears control state and counters.
//  Input is stalled only during a CRC pass or while a result is loaded, which
//  first waits for a full result register to drain.
// ----------------------------------------------------------------------------
module can_frame_byte_deframer
   import cfdd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [15:0]          rsp_frame_ident,
   output logic [3:0]           rsp_payload_length,
   output logic [63:0]          rsp_payload,
   output logic [15:0]          rsp_check_received,
   output logic [15:0]          rsp_check_computed,
   output logic [31:0]          rsp_rejected_count,
   output logic [31:0]          rsp_bad_frame_count,
   // configuration port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   typedef enum logic [1:0] {S_RUN, S_CRC, S_EMIT} state_type;

   state_type   state_ff, state_in;
   logic [7:0]  first_ff, second_ff;
   logic [31:0] poly_ff;
   logic [3:0]  pos_ff, pos_in;
   logic [3:0]  dlc_ff, dlc_in;
   logic [15:0] ident_ff, ident_in;
   logic [63:0] payload_ff, payload_in;
   logic [15:0] chk_rx_ff, chk_rx_in;
   logic [31:0] group_ff, group_in;
   logic        final_ff, final_in;
   logic        err_ff, err_in;
   logic [31:0] rej_ff, rej_in;
   logic [31:0] bad_ff, bad_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_ident_ff, rsp_ident_in;
   logic [3:0]  rsp_len_ff, rsp_len_in;
   logic [63:0] rsp_payload_ff, rsp_payload_in;
   logic [15:0] rsp_chk_rx_ff, rsp_chk_rx_in;
   logic [15:0] rsp_chk_my_ff, rsp_chk_my_in;
   logic [31:0] rsp_rej_ff, rsp_rej_in;
   logic [31:0] rsp_bad_ff, rsp_bad_in;

   crc_cmd_type crc_cmd;
   crc_sts_type crc_sts;

   logic        accept;
   logic [3:0]  idx;
   logic [3:0]  crc_len;
   logic [1:0]  lane;
   logic [2:0]  pidx;
   logic        out_free;
   logic        mismatch;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_RUN);
   assign idx      = pos_ff - 4'd2;
   assign crc_len  = dlc_ff + 4'd3;
   assign lane     = idx[1:0];
   assign pidx     = 3'(idx - 4'd3);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign mismatch = (chk_rx_ff != crc_sts.check);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= FIRST_START_RST;
         second_ff <= SECOND_START_RST;
         poly_ff   <= CRC_POLY_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIRST_START:  first_ff  <= csr_wdata[7:0];
            CSR_SECOND_START: second_ff <= csr_wdata[7:0];
            CSR_CRC_POLY:     poly_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // frame sequencer
   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      dlc_in         = dlc_ff;
      ident_in       = ident_ff;
      payload_in     = payload_ff;
      chk_rx_in      = chk_rx_ff;
      group_in       = group_ff;
      final_in       = final_ff;
      err_in         = err_ff;
      rej_in         = rej_ff;
      bad_in         = bad_ff;
      crc_cmd        = '0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_ident_in   = rsp_ident_ff;
      rsp_len_in     = rsp_len_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_chk_rx_in  = rsp_chk_rx_ff;
      rsp_chk_my_in  = rsp_chk_my_ff;
      rsp_rej_in     = rsp_rej_ff;
      rsp_bad_in     = rsp_bad_ff;

      case (state_ff)
         S_RUN: begin
            if (accept) begin
               if (pos_ff == 4'd0) begin
                  // hunt first start byte
                  if (req_rx_byte == first_ff) begin
                     pos_in = 4'd1;
                  end else begin
                     rej_in = rej_ff + 32'd1;
                  end
               end else if (pos_ff == 4'd1) begin
                  // second start byte, else restart the hunt
                  if (req_rx_byte == second_ff) begin
                     pos_in = 4'd2;
                  end else begin
                     pos_in = 4'd0;
                     rej_in = rej_ff + 32'd1;
                  end
               end else if (pos_ff == 4'd2) begin
                  // length byte
                  if (req_rx_byte > 8'(MAX_PAYLOAD)) begin
                     err_in   = 1'b1;
                     pos_in   = 4'd0;
                     state_in = S_EMIT;
                  end else begin
                     dlc_in       = req_rx_byte[3:0];
                     payload_in   = '0;
                     group_in     = {24'd0, req_rx_byte};
                     crc_cmd.init = 1'b1;
                     pos_in       = 4'd3;
                  end
               end else begin
                  pos_in = pos_ff + 4'd1;
                  if (idx < crc_len) begin
                     // byte covered by the CRC
                     if (lane == 2'd0) begin
                        group_in = {24'd0, req_rx_byte};
                     end else begin
                        group_in[{lane, 3'b000} +: 8] = req_rx_byte;
                     end
                     if (idx == 4'd1) begin
                        ident_in[7:0] = req_rx_byte;
                     end else if (idx == 4'd2) begin
                        ident_in[15:8] = req_rx_byte;
                     end else begin
                        payload_in[{pidx, 3'b000} +: 8] = req_rx_byte;
                     end
                     if (lane == 2'd3) begin
                        crc_cmd.start = 1'b1;
                        final_in      = 1'b0;
                        state_in      = S_CRC;
                     end
                  end else if (idx == crc_len) begin
                     chk_rx_in[7:0] = req_rx_byte;
                  end else begin
                     // last check byte: flush a short group if there is one, then report
                     chk_rx_in[15:8] = req_rx_byte;
                     pos_in          = 4'd0;
                     if (crc_len[1:0] != 2'd0) begin
                        crc_cmd.start = 1'b1;
                        final_in      = 1'b1;
                        state_in      = S_CRC;
                     end else begin
                        state_in = S_EMIT;
                     end
                  end
               end
            end
         end
         S_CRC: begin
            if (!crc_sts.busy) begin
               state_in = final_ff ? S_EMIT : S_RUN;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rej_in   = rej_ff;
               err_in       = 1'b0;
               state_in     = S_RUN;
               if (err_ff) begin
                  rsp_status_in  = ST_LENGTH;
                  rsp_ident_in   = '0;
                  rsp_len_in     = '0;
                  rsp_payload_in = '0;
                  rsp_chk_rx_in  = '0;
                  rsp_chk_my_in  = '0;
                  rsp_bad_in     = bad_ff;
               end else begin
                  rsp_status_in  = mismatch ? ST_MISMATCH : ST_GOOD;
                  rsp_ident_in   = ident_ff;
                  rsp_len_in     = dlc_ff;
                  rsp_payload_in = payload_ff;
                  rsp_chk_rx_in  = chk_rx_ff;
                  rsp_chk_my_in  = crc_sts.check;
                  bad_in         = mismatch ? bad_ff + 32'd1 : bad_ff;
                  rsp_bad_in     = bad_in;
               end
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         pos_ff       <= '0;
         final_ff     <= 1'b0;
         err_ff       <= 1'b0;
         rej_ff       <= '0;
         bad_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         final_ff     <= final_in;
         err_ff       <= err_in;
         rej_ff       <= rej_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dlc_ff         <= dlc_in;
      ident_ff       <= ident_in;
      payload_ff     <= payload_in;
      chk_rx_ff      <= chk_rx_in;
      group_ff       <= group_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_ident_ff   <= rsp_ident_in;
      rsp_len_ff     <= rsp_len_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_chk_rx_ff  <= rsp_chk_rx_in;
      rsp_chk_my_ff  <= rsp_chk_my_in;
      rsp_rej_ff     <= rsp_rej_in;
      rsp_bad_ff     <= rsp_bad_in;
   end

   // bit-serial CRC over the current group, including the byte taken now
   cfdd_crc u_crc (
      .clock      (clock),
      .reset      (reset),
      .cmd        (crc_cmd),
      .group_word (group_in),
      .poly       (poly_ff),
      .sts        (crc_sts)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_frame_ident     = rsp_ident_ff;
   assign rsp_payload_length  = rsp_len_ff;
   assign rsp_payload         = rsp_payload_ff;
   assign rsp_check_received  = rsp_chk_rx_ff;
   assign rsp_check_computed  = rsp_chk_my_ff;
   assign rsp_rejected_count  = rsp_rej_ff;
   assign rsp_bad_frame_count = rsp_bad_ff;

endmodule

// ===== rtl/cfdd_chk.sv =====
// ----------------------------------------------------------------------------
// cfdd_chk
// Port-level checks on the deframer results, bound to the top level.
// ----------------------------------------------------------------------------
module cfdd_chk
   import cfdd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_frame_ident,
   input logic [3:0]  rsp_payload_length,
   input logic [63:0] rsp_payload,
   input logic [15:0] rsp_check_received,
   input logic [15:0] rsp_check_computed
);

   // a good frame has matching check values
   a_good_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_GOOD |-> rsp_check_received == rsp_check_computed)
      else $error("good status with differing check values");

   // a length error carries no frame contents
   a_len_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_LENGTH |->
         rsp_frame_ident == 16'd0 && rsp_payload == 64'd0 && rsp_payload_length == 4'd0)
      else $error("length error result carries frame data");

   // reported length never exceeds the limit, status code is defined
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload_length <= 4'(MAX_PAYLOAD) && rsp_status <= ST_LENGTH)
      else $error("result length or status out of range");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload) && $stable(rsp_status))
      else $error("stalled result changed");

endmodule

bind can_frame_byte_deframer cfdd_chk u_cfdd_chk (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_frame_ident    (rsp_frame_ident),
   .rsp_payload_length (rsp_payload_length),
   .rsp_payload        (rsp_payload),
   .rsp_check_received (rsp_check_received),
   .rsp_check_computed (rsp_check_computed)
);
